/* hdl/polygon_flat_normal_top_macros.svh */
// Assertion macros for the polygon flat normal block
`ifndef POLYGON_FLAT_NORMAL_TOP_MACROS_SVH
`define POLYGON_FLAT_NORMAL_TOP_MACROS_SVH

// same-cycle implication
`define PFN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfn check failed");

// next-cycle implication
`define PFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfn check failed");

`endif

/* hdl/pfn_pkg.sv */
package pfn_pkg;

    localparam int AXES        = 3;
    localparam int COORD_BITS  = 24;
    localparam int NORMAL_BITS = 16;
    localparam int SUM_BITS    = 60;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int MAG_BITS    = SUM_BITS;
    localparam int HALF_BITS   = MAG_BITS / 2;
    localparam int HPROD_BITS  = 2 * HALF_BITS;
    localparam int SQ_BITS     = 2 * MAG_BITS;
    localparam int ROOT_BITS   = MAG_BITS;
    localparam int REM_BITS    = ROOT_BITS + 3;
    localparam int NUM_BITS    = MAG_BITS + NORMAL_BITS - 1;
    localparam int SQ_STEPS    = AXES * 3;
    localparam int CNT_BITS    = $clog2(ROOT_BITS + 1);
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_PTR_BITS = $clog2(FQ_DEPTH);

    localparam logic [NORMAL_BITS-1:0] NORM_MAX = {1'b0, {(NORMAL_BITS-1){1'b1}}};
    localparam logic signed [NORMAL_BITS-1:0] NORM_NEG_LIMIT =
        {1'b1, {(NORMAL_BITS-1){1'b0}}};

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [DIFF_BITS-1:0]   diff_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic signed [NORMAL_BITS-1:0] normal_t;

    typedef struct packed {
        sum_t x;
        sum_t y;
        sum_t z;
    } face_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fq_status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SQRT,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

/* hdl/polygon_flat_normal_top.sv */
// channel  | handshake          | word
// vertex   | push / full        | pos_x, pos_y, pos_z, last_vertex
// normal   | empty / pop        | normal_x, normal_y, normal_z, degenerate
// config   | cfg_write          | cfg_data (flip_orientation)
//
// Vertices are taken one per cycle while full is low; the cross products sum in a two-stage front.
// Each face then passes through the back in turn: the squares sum on one
// 30x30 multiplier, then 60 square-root steps, 16 divide steps and handoff.
// A four-face queue sits between front and back; full rises when it is full
// and a last vertex waits. Reset clears all control state and the flip bit.
module polygon_flat_normal_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pfn_pkg::coord_t  pos_x,
    input  pfn_pkg::coord_t  pos_y,
    input  pfn_pkg::coord_t  pos_z,
    input  logic             last_vertex,
    output logic             empty,
    input  logic             pop,
    output pfn_pkg::normal_t normal_x,
    output pfn_pkg::normal_t normal_y,
    output pfn_pkg::normal_t normal_z,
    output logic             degenerate,
    input  logic             cfg_write,
    input  logic             cfg_data
);
    import pfn_pkg::*;

    logic       fq_push, fq_pop;
    face_t      fq_wdata, fq_rdata;
    fq_status_t fq_st;

    pfn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .last_vertex (last_vertex),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .fq_push     (fq_push),
        .fq_data     (fq_wdata),
        .fq_full     (fq_st.full)
    );

    pfn_fq u_fq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_wdata),
        .rd_en   (fq_pop),
        .rd_data (fq_rdata),
        .status  (fq_st)
    );

    pfn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fq_st      (fq_st),
        .fq_data    (fq_rdata),
        .fq_pop     (fq_pop),
        .empty      (empty),
        .pop        (pop),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .degenerate (degenerate)
    );

endmodule

/* hdl/pfn_front.sv */
module pfn_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  pfn_pkg::coord_t pos_x,
    input  pfn_pkg::coord_t pos_y,
    input  pfn_pkg::coord_t pos_z,
    input  logic           last_vertex,
    input  logic           cfg_write,
    input  logic           cfg_data,
    output logic           fq_push,
    output pfn_pkg::face_t fq_data,
    input  logic           fq_full
);
    import pfn_pkg::*;

    logic        flip_reg;
    logic [1:0]  seen_reg;
    coord_t      first_reg [AXES];
    coord_t      prev_reg [AXES];
    logic        s1_vld_reg, s1_last_reg, s1_cross_reg, s1_flip_reg;
    prod_t       s1_p_reg [2*AXES];
    sum_t        sum_reg [AXES];

    coord_t      v [AXES];
    diff_t       a [AXES];
    diff_t       b [AXES];
    prod_t       p_next [2*AXES];
    sum_t        sum_next [AXES];
    logic        accept, adv, fold;

    always_comb
    begin
        v[0] = pos_x;
        v[1] = pos_y;
        v[2] = pos_z;
        for (int i = 0; i < AXES; i++)
        begin
            a[i] = diff_t'(prev_reg[i]) - diff_t'(first_reg[i]);
            b[i] = diff_t'(v[i]) - diff_t'(first_reg[i]);
        end
        p_next[0] = a[1] * b[2];
        p_next[1] = a[2] * b[1];
        p_next[2] = a[2] * b[0];
        p_next[3] = a[0] * b[2];
        p_next[4] = a[0] * b[1];
        p_next[5] = a[1] * b[0];
    end

    assign adv    = !s1_last_reg || !fq_full;
    assign full   = s1_vld_reg && !adv;
    assign accept = push && !full;
    assign fold   = s1_vld_reg && adv;

    // sum +/- (p_even - p_odd)
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (!s1_cross_reg)
                sum_next[i] = sum_reg[i];
            else if (s1_flip_reg)
                sum_next[i] = sum_reg[i] - sum_t'(s1_p_reg[2*i]) + sum_t'(s1_p_reg[2*i+1]);
            else
                sum_next[i] = sum_reg[i] + sum_t'(s1_p_reg[2*i]) - sum_t'(s1_p_reg[2*i+1]);
        end
    end

    assign fq_push   = fold && s1_last_reg;
    assign fq_data.x = sum_next[0];
    assign fq_data.y = sum_next[1];
    assign fq_data.z = sum_next[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg    <= 1'b0;
            seen_reg    <= 2'd0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write)
                flip_reg <= cfg_data;
            if (accept)
            begin
                if (last_vertex)
                    seen_reg <= 2'd0;
                else if (seen_reg != 2'd2)
                    seen_reg <= seen_reg + 2'd1;
                s1_vld_reg  <= 1'b1;
                s1_last_reg <= last_vertex;
            end
            else if (adv)
            begin
                s1_vld_reg  <= 1'b0;
                s1_last_reg <= 1'b0;
            end
            if (fold)
            begin
                for (int i = 0; i < AXES; i++)
                    sum_reg[i] <= s1_last_reg ? '0 : sum_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cross_reg <= (seen_reg == 2'd2);
            s1_flip_reg  <= flip_reg;
            for (int i = 0; i < 2*AXES; i++)
                s1_p_reg[i] <= p_next[i];
            for (int i = 0; i < AXES; i++)
            begin
                if (seen_reg == 2'd0)
                    first_reg[i] <= v[i];
                else
                    prev_reg[i] <= v[i];
            end
        end
    end

endmodule

/* hdl/pfn_fq.sv */
module pfn_fq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  pfn_pkg::face_t      wr_data,
    input  logic                rd_en,
    output pfn_pkg::face_t      rd_data,
    output pfn_pkg::fq_status_t status
);
    import pfn_pkg::*;

    face_t                 mem [FQ_DEPTH];
    logic [FQ_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FQ_PTR_BITS:0]   cnt_reg;
    logic                  do_wr, do_rd;

    assign status.full  = (cnt_reg == (FQ_PTR_BITS+1)'(FQ_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && !status.empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == FQ_PTR_BITS'(FQ_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == FQ_PTR_BITS'(FQ_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

/* hdl/pfn_back.sv */
module pfn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pfn_pkg::fq_status_t fq_st,
    input  pfn_pkg::face_t      fq_data,
    output logic                fq_pop,
    output logic                empty,
    input  logic                pop,
    output pfn_pkg::normal_t    normal_x,
    output pfn_pkg::normal_t    normal_y,
    output pfn_pkg::normal_t    normal_z,
    output logic                degenerate
);
    import pfn_pkg::*;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    back_state_t              state_reg, state_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [1:0]               comp_reg, part_reg, prod_part_reg;
    logic                     prod_vld_reg;
    logic [HPROD_BITS-1:0]    prod_reg;
    logic [MAG_BITS-1:0]      mag_reg [AXES];
    logic                     neg_reg [AXES];
    logic                     degen_reg;
    logic [SQ_BITS-1:0]       acc_reg;
    logic [REM_BITS-1:0]      rem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [NUM_BITS-1:0]      d_reg;
    logic [NUM_BITS-1:0]      drem_reg [AXES];
    logic [NORMAL_BITS-1:0]   q_reg [AXES];
    logic                     out_vld_reg, out_degen_reg;
    normal_t                  out_reg [AXES];

    sum_t                     s_in [AXES];
    logic [MAG_BITS-1:0]      mag_in [AXES];
    logic                     face_zero;
    logic                     mul_issue, load_out;
    logic [MAG_BITS-1:0]      mag_sel;
    logic [HALF_BITS-1:0]     op_a, op_b;
    logic [SQ_BITS-1:0]       addend;
    logic [REM_BITS-1:0]      rem_sh, trial;
    logic                     sq_ge;
    logic [NORMAL_BITS-1:0]   q_clamp [AXES];
    normal_t                  out_val [AXES];

    always_comb
    begin
        s_in[0] = fq_data.x;
        s_in[1] = fq_data.y;
        s_in[2] = fq_data.z;
        face_zero = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            mag_in[i] = s_in[i][SUM_BITS-1] ? MAG_BITS'(-s_in[i]) : MAG_BITS'(s_in[i]);
            if (s_in[i] != '0)
                face_zero = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!fq_st.empty) state_next = face_zero ? B_DONE : B_SQ;
            B_SQ:   if (cnt_reg == CNT_BITS'(SQ_STEPS)) state_next = B_SQRT;
            B_SQRT: if (cnt_reg == CNT_BITS'(ROOT_BITS-1)) state_next = B_PREP;
            B_PREP: state_next = B_DIV;
            B_DIV:  if (cnt_reg == CNT_BITS'(NORMAL_BITS-1)) state_next = B_DONE;
            B_DONE: if (!out_vld_reg) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        fq_pop    = 1'b0;
        mul_issue = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            B_IDLE: fq_pop = !fq_st.empty;
            B_SQ:   mul_issue = (cnt_reg < CNT_BITS'(SQ_STEPS));
            B_DONE: load_out = !out_vld_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        mag_sel = mag_reg[comp_reg];
        op_a = (part_reg == PART_HH) ? mag_sel[MAG_BITS-1:HALF_BITS] : mag_sel[HALF_BITS-1:0];
        op_b = (part_reg == PART_LL) ? mag_sel[HALF_BITS-1:0] : mag_sel[MAG_BITS-1:HALF_BITS];
        case (prod_part_reg)
            PART_LL: addend = SQ_BITS'(prod_reg);
            PART_HL: addend = SQ_BITS'(prod_reg) << (HALF_BITS + 1);
            default: addend = SQ_BITS'(prod_reg) << (2 * HALF_BITS);
        endcase
        rem_sh = {rem_reg[REM_BITS-3:0], acc_reg[SQ_BITS-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        sq_ge  = (rem_sh >= trial);
        for (int i = 0; i < AXES; i++)
        begin
            q_clamp[i] = (q_reg[i] > NORM_MAX) ? NORM_MAX : q_reg[i];
            out_val[i] = neg_reg[i] ? -normal_t'(q_clamp[i]) : normal_t'(q_clamp[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            cnt_reg      <= '0;
            comp_reg     <= '0;
            part_reg     <= PART_LL;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
            prod_vld_reg <= mul_issue;
            if (state_reg == B_IDLE)
            begin
                comp_reg <= '0;
                part_reg <= PART_LL;
            end
            else if (mul_issue)
            begin
                if (part_reg == PART_HH)
                begin
                    part_reg <= PART_LL;
                    comp_reg <= comp_reg + 2'd1;
                end
                else
                    part_reg <= part_reg + 2'd1;
            end
            if (load_out)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= op_a * op_b;
        prod_part_reg <= part_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                acc_reg   <= '0;
                rem_reg   <= '0;
                root_reg  <= '0;
                degen_reg <= face_zero;
                for (int i = 0; i < AXES; i++)
                begin
                    mag_reg[i] <= mag_in[i];
                    neg_reg[i] <= s_in[i][SUM_BITS-1];
                    q_reg[i]   <= '0;
                end
            end
            B_SQ:
                if (prod_vld_reg)
                    acc_reg <= acc_reg + addend;
            B_SQRT:
            begin
                acc_reg  <= acc_reg << 2;
                rem_reg  <= sq_ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_BITS-2:0], sq_ge};
            end
            B_PREP:
            begin
                d_reg <= NUM_BITS'(root_reg) << (NORMAL_BITS - 1);
                for (int i = 0; i < AXES; i++)
                    drem_reg[i] <= (NUM_BITS'(mag_reg[i]) << (NORMAL_BITS - 1))
                                   - NUM_BITS'(mag_reg[i]);
            end
            B_DIV:
            begin
                d_reg <= d_reg >> 1;
                for (int i = 0; i < AXES; i++)
                begin
                    if (drem_reg[i] >= d_reg)
                        drem_reg[i] <= drem_reg[i] - d_reg;
                    q_reg[i] <= {q_reg[i][NORMAL_BITS-2:0], drem_reg[i] >= d_reg};
                end
            end
            default: ;
        endcase
        if (load_out)
        begin
            out_degen_reg <= degen_reg;
            for (int i = 0; i < AXES; i++)
                out_reg[i] <= out_val[i];
        end
    end

    assign empty      = !out_vld_reg;
    assign normal_x   = out_reg[0];
    assign normal_y   = out_reg[1];
    assign normal_z   = out_reg[2];
    assign degenerate = out_degen_reg;

endmodule

/* hdl/pfn_checker.sv */
`include "polygon_flat_normal_top_macros.svh"

module pfn_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input pfn_pkg::normal_t normal_x,
    input pfn_pkg::normal_t normal_y,
    input pfn_pkg::normal_t normal_z,
    input logic             degenerate
);
    import pfn_pkg::*;

    `PFN_ASSERT_IMPL(a_degen_zero, clk, rst_n, !empty && degenerate, normal_x == '0 && normal_y == '0 && normal_z == '0)
    `PFN_ASSERT_IMPL(a_live_nonzero, clk, rst_n, !empty && !degenerate, normal_x != '0 || normal_y != '0 || normal_z != '0)
    `PFN_ASSERT_IMPL(a_in_range, clk, rst_n, !empty, normal_x != NORM_NEG_LIMIT && normal_y != NORM_NEG_LIMIT && normal_z != NORM_NEG_LIMIT)
    `PFN_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(normal_x) && $stable(degenerate))

endmodule

bind polygon_flat_normal_top pfn_checker u_pfn_checker (.*);
